/* sv/spd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the sensor packet deframer: operation codes,
// result kinds, error causes, parser phases and the input stage item.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FINISH  = 1'b1;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_LENGTH   = 2'd1;
  localparam logic [1:0] CAUSE_CHECKSUM = 2'd2;
  localparam logic [1:0] CAUSE_TIMEOUT  = 2'd3;

  localparam logic [0:0] REG_TIMEOUT  = 1'b0;
  localparam logic [0:0] REG_CAPACITY = 1'b1;

  localparam logic [7:0] HDR_BYTE0 = 8'hEF;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [15:0] CAPACITY_RESET = 16'd16;
  localparam logic [15:0] TICKS_MAX      = 16'hFFFF;
  localparam logic [15:0] CRC_BYTES      = 16'd2;

  typedef enum logic [11:0] {
    PH_HUNT    = 12'b0000_0000_0001,
    PH_HDR2    = 12'b0000_0000_0010,
    PH_ADDR0   = 12'b0000_0000_0100,
    PH_ADDR1   = 12'b0000_0000_1000,
    PH_ADDR2   = 12'b0000_0001_0000,
    PH_ADDR3   = 12'b0000_0010_0000,
    PH_PID     = 12'b0000_0100_0000,
    PH_LENH    = 12'b0000_1000_0000,
    PH_LENL    = 12'b0001_0000_0000,
    PH_PAYLOAD = 12'b0010_0000_0000,
    PH_SUMH    = 12'b0100_0000_0000,
    PH_SUML    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

endpackage : spd_pkg
`default_nettype wire

/* sv/spd_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spd_in_stage
// Input register. Holds one accepted item until the parser takes it and
// refills in the same cycle, so one item can enter per clock while the parser keeps taking.
// ----------------------------------------------------------------------------
module spd_in_stage
  import spd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output item_t           item
);

  logic       valid_r, valid_nxt;
  logic [1:0] op_r;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.operation = op_r;
  assign item.rx_byte   = byte_r;

endmodule : spd_in_stage
`default_nettype wire

/* sv/spd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spd_parser
// Packet parser, checksum, tick timer and result register. Takes the item in
// the input register whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
module spd_parser
  import spd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  item_t            item,
  output logic             take,
  input  wire logic [15:0] timeout_ticks,
  input  wire logic [15:0] buffer_capacity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_payload_index,
  output logic [7:0]       out_data_byte,
  output logic             out_status,
  output logic [1:0]       out_error_cause,
  output logic [7:0]       out_confirmation_code,
  output logic [15:0]      out_payload_count
);

  logic        armed_r, armed_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic        res_v;
  logic        res_kind;
  logic [15:0] res_index;
  logic [7:0]  res_byte;
  logic [1:0]  res_cause;
  logic        res_finish;

  logic        out_valid_r;
  logic        kind_r;
  logic [15:0] index_r;
  logic [7:0]  byte_r;
  logic        status_r;
  logic [1:0]  cause_r;
  logic [7:0]  conf_r;
  logic [15:0] count_r;

  logic [7:0]  b;
  logic [15:0] sum_add;
  logic [15:0] len_full;
  logic [15:0] pos_inc;

  assign take    = item.valid && (!out_valid_r || out_ready);
  assign b       = item.rx_byte;
  assign sum_add = sum_r + {8'd0, b};
  assign len_full = {len_r[15:8], b};
  assign pos_inc = pos_r + 16'd1;

  always_comb begin
    armed_nxt  = armed_r;
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    sum_hi_nxt = sum_hi_r;
    first_nxt  = first_r;
    ticks_nxt  = ticks_r;
    res_v      = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_index  = 16'd0;
    res_byte   = 8'd0;
    res_cause  = CAUSE_NONE;
    res_finish = 1'b0;
    if (take) begin
      case (item.operation)
        OP_START: begin
          armed_nxt  = 1'b1;
          phase_nxt  = PH_HUNT;
          len_nxt    = 16'd0;
          pos_nxt    = 16'd0;
          sum_nxt    = 16'd0;
          sum_hi_nxt = 8'd0;
          first_nxt  = 8'd0;
          ticks_nxt  = 16'd0;
        end
        OP_BYTE: begin
          if (armed_r) begin
            case (phase_r)
              PH_HDR2: begin
                phase_nxt = (b == HDR_BYTE1) ? PH_ADDR0 : PH_HUNT;
              end
              PH_ADDR0: phase_nxt = PH_ADDR1;
              PH_ADDR1: phase_nxt = PH_ADDR2;
              PH_ADDR2: phase_nxt = PH_ADDR3;
              PH_ADDR3: phase_nxt = PH_PID;
              PH_PID: begin
                sum_nxt   = {8'd0, b};
                phase_nxt = PH_LENH;
              end
              PH_LENH: begin
                len_nxt   = {b, 8'd0};
                sum_nxt   = sum_add;
                phase_nxt = PH_LENL;
              end
              PH_LENL: begin
                len_nxt = len_full;
                sum_nxt = sum_add;
                if (len_full < CRC_BYTES) begin
                  res_finish = 1'b1;
                  res_cause  = CAUSE_LENGTH;
                end else begin
                  pos_nxt   = 16'd0;
                  phase_nxt = (len_full == CRC_BYTES) ? PH_SUMH : PH_PAYLOAD;
                end
              end
              PH_PAYLOAD: begin
                sum_nxt = sum_add;
                if (pos_r == 16'd0) begin
                  first_nxt = b;
                end
                if (pos_r < buffer_capacity) begin
                  res_v     = 1'b1;
                  res_index = pos_r;
                  res_byte  = b;
                end
                pos_nxt = pos_inc;
                if (pos_inc >= (len_r - CRC_BYTES)) begin
                  phase_nxt = PH_SUMH;
                end
              end
              PH_SUMH: begin
                sum_hi_nxt = b;
                phase_nxt  = PH_SUML;
              end
              PH_SUML: begin
                res_finish = 1'b1;
                res_cause  = ({sum_hi_r, b} == sum_r) ? CAUSE_NONE : CAUSE_CHECKSUM;
              end
              default: begin
                phase_nxt = (b == HDR_BYTE0) ? PH_HDR2 : PH_HUNT;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (armed_r) begin
            if (ticks_r != TICKS_MAX) begin
              ticks_nxt = ticks_r + 16'd1;
            end
            if (ticks_nxt >= timeout_ticks) begin
              res_finish = 1'b1;
              res_cause  = CAUSE_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
      if (res_finish) begin
        armed_nxt = 1'b0;
        res_v     = 1'b1;
        res_kind  = KIND_FINISH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      phase_r  <= PH_HUNT;
      len_r    <= 16'd0;
      pos_r    <= 16'd0;
      sum_r    <= 16'd0;
      sum_hi_r <= 8'd0;
      first_r  <= 8'd0;
      ticks_r  <= 16'd0;
    end else begin
      armed_r  <= armed_nxt;
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      sum_hi_r <= sum_hi_nxt;
      first_r  <= first_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_v) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      kind_r  <= res_kind;
      index_r <= res_index;
      byte_r  <= res_byte;
      status_r <= res_finish && (res_cause != CAUSE_NONE);
      cause_r <= res_cause;
      conf_r  <= (res_finish && (pos_r != 16'd0)) ? first_r : 8'd0;
      count_r <= res_finish ? pos_r : 16'd0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = kind_r;
  assign out_payload_index     = index_r;
  assign out_data_byte         = byte_r;
  assign out_status            = status_r;
  assign out_error_cause       = cause_r;
  assign out_confirmation_code = conf_r;
  assign out_payload_count     = count_r;

endmodule : spd_parser
`default_nettype wire

/* sv/sensor_packet_deframer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_packet_deframer_top
// Receive-side deframer for sum16-checksum serial sensor packets.
// ----------------------------------------------------------------------------
// The block accepts one item (start, received byte or tick) per clock cycle
// while results are taken. An accepted item is held in the input register;
// the parser, checksum adder and tick timer then update together and load the
// result register, which drives the out_ channel. A result that is not taken
// stalls the parser, and the input register then holds one more item before
// in_ready drops. Configuration writes are taken on every cycle (cfg_ready is
// always high); index 0 sets the timeout in ticks, index 1 the maximum number
// of payload bytes emitted per packet.
module sensor_packet_deframer_top
  import spd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_payload_index,
  output logic [7:0]       out_data_byte,
  output logic             out_status,
  output logic [1:0]       out_error_cause,
  output logic [7:0]       out_confirmation_code,
  output logic [15:0]      out_payload_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] timeout_r;
  logic [15:0] capacity_r;
  item_t       item;
  logic        take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RESET;
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_r  <= cfg_data;
        REG_CAPACITY: capacity_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spd_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .take         (take),
    .item         (item)
  );

  spd_parser u_parser (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .item                  (item),
    .take                  (take),
    .timeout_ticks         (timeout_r),
    .buffer_capacity       (capacity_r),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_payload_index     (out_payload_index),
    .out_data_byte         (out_data_byte),
    .out_status            (out_status),
    .out_error_cause       (out_error_cause),
    .out_confirmation_code (out_confirmation_code),
    .out_payload_count     (out_payload_count)
  );

`ifndef SYNTHESIS
  a_finish_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FINISH) |->
      (out_status == (out_error_cause != CAUSE_NONE)))
    else $error("finish status disagrees with error cause");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PAYLOAD) |->
      (!out_status && (out_error_cause == CAUSE_NONE) && (out_payload_count == 16'd0)))
    else $error("payload result carries finish fields");

  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    item.valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are blocked");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    item.valid && !take |=> item.valid && $stable(item.operation) && $stable(item.rx_byte))
    else $error("input register lost an item that was not taken");
`endif

endmodule : sensor_packet_deframer_top
`default_nettype wire

/* dv/sensor_packet_deframer_top_tb.sv */
// ----------------------------------------------------------------------------
// sensor_packet_deframer_top_tb
// Self-checking testbench of the sum16 packet deframer. A short table of
// directed items covers idle and unused operations, a length-two packet and a
// length error. Randomized packets then follow over several register
// settings, each transfer checked against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_top_tb;
  import spd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 165;
  localparam int N_PHASES = 8;
  localparam logic [15:0] PHASE_TIMEOUT [N_PHASES] =
    '{16'd1, 16'd65535, 16'd40, 16'd3, 16'd1000, 16'd65535, 16'd120, 16'd8};
  localparam logic [15:0] PHASE_CAPACITY [N_PHASES] =
    '{16'd0, 16'd65535, 16'd5, 16'd16, 16'd1, 16'd0, 16'd65535, 16'd2};

  typedef struct packed {
    logic        kind;
    logic [15:0] pay_index;
    logic [7:0]  data_byte;
    logic        status;
    logic [1:0]  cause;
    logic [7:0]  confirm;
    logic [15:0] count;
  } result_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
    bit         typed;
    bit         has;
    result_t    r;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [15:0] out_payload_index;
  logic [7:0]  out_data_byte;
  logic        out_status;
  logic [1:0]  out_error_cause;
  logic [7:0]  out_confirmation_code;
  logic [15:0] out_payload_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  sensor_packet_deframer_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_payload_index     (out_payload_index),
    .out_data_byte         (out_data_byte),
    .out_status            (out_status),
    .out_error_cause       (out_error_cause),
    .out_confirmation_code (out_confirmation_code),
    .out_payload_count     (out_payload_count),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Parser model state and register copies.
  logic [15:0] cfg_timeout  = TIMEOUT_RESET;
  logic [15:0] cfg_capacity = CAPACITY_RESET;
  logic        rx_armed     = 1'b0;
  phase_t      phase        = PH_HUNT;
  logic [15:0] declared_len = '0;
  logic [15:0] pos          = '0;
  logic [15:0] csum         = '0;
  logic [7:0]  sum_hi       = '0;
  logic [7:0]  first_byte   = '0;
  logic [15:0] ticks        = '0;

  result_t   awaited_results [$];
  stim_row_t stim_rows [$];
  int        fed_items  = 0;
  int        fail_count = 0;
  bit        calm       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #9_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void clear_parser();
    phase        = PH_HUNT;
    declared_len = '0;
    pos          = '0;
    csum         = '0;
    sum_hi       = '0;
    first_byte   = '0;
    ticks        = '0;
  endfunction

  function automatic result_t finish_result(input logic [1:0] cause);
    result_t r;
    r         = '0;
    r.kind    = KIND_FINISH;
    r.status  = (cause != CAUSE_NONE);
    r.cause   = cause;
    r.confirm = (pos != 16'd0) ? first_byte : 8'h00;
    r.count   = pos;
    rx_armed  = 1'b0;
    return r;
  endfunction

  task automatic deframe_predict(input logic [1:0] op, input logic [7:0] b,
                                 output bit produced, output result_t r);
    produced = 1'b0;
    r = '0;
    if (op == OP_START) begin
      clear_parser();
      rx_armed = 1'b1;
    end else if (rx_armed && op == OP_TICK) begin
      if (ticks != TICKS_MAX) ticks = ticks + 16'd1;
      if (ticks >= cfg_timeout) begin
        r = finish_result(CAUSE_TIMEOUT);
        produced = 1'b1;
      end
    end else if (rx_armed && op == OP_BYTE) begin
      case (phase)
        PH_HDR2: phase = (b == HDR_BYTE1) ? PH_ADDR0 : PH_HUNT;
        PH_ADDR0: phase = PH_ADDR1;
        PH_ADDR1: phase = PH_ADDR2;
        PH_ADDR2: phase = PH_ADDR3;
        PH_ADDR3: phase = PH_PID;
        PH_PID: begin
          csum  = {8'h00, b};
          phase = PH_LENH;
        end
        PH_LENH: begin
          declared_len = {b, 8'h00};
          csum  = csum + {8'h00, b};
          phase = PH_LENL;
        end
        PH_LENL: begin
          declared_len = declared_len | {8'h00, b};
          csum = csum + {8'h00, b};
          if (declared_len < CRC_BYTES) begin
            r = finish_result(CAUSE_LENGTH);
            produced = 1'b1;
          end else begin
            pos   = '0;
            phase = (declared_len == CRC_BYTES) ? PH_SUMH : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          csum = csum + {8'h00, b};
          if (pos == 16'd0) first_byte = b;
          if (pos < cfg_capacity) begin
            r.kind      = KIND_PAYLOAD;
            r.pay_index = pos;
            r.data_byte = b;
            produced    = 1'b1;
          end
          pos = pos + 16'd1;
          if (pos >= declared_len - CRC_BYTES) phase = PH_SUMH;
        end
        PH_SUMH: begin
          sum_hi = b;
          phase  = PH_SUML;
        end
        PH_SUML: begin
          r = finish_result(({sum_hi, b} == csum) ? CAUSE_NONE : CAUSE_CHECKSUM);
          produced = 1'b1;
        end
        default: phase = (b == HDR_BYTE0) ? PH_HDR2 : PH_HUNT;
      endcase
    end
  endtask

  // Called at a rising edge; returns at the edge where the item transferred.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input bit typed = 1'b0, input bit has = 1'b0,
                           input result_t typed_r = '0);
    int unsigned gap;
    bit          produced;
    result_t     r;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    deframe_predict(op, b, produced, r);
    if (typed) begin
      produced = has;
      r = typed_r;
    end
    if (produced) awaited_results.push_back(r);
    fed_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] timeout, input logic [15:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= timeout;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_timeout = timeout;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_capacity = cap;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] b);
    stim_rows.push_back('{op, b, 1'b0, 1'b0, '0});
  endtask

  task automatic add_typed(input logic [1:0] op, input logic [7:0] b,
                           input bit has, input result_t r);
    stim_rows.push_back('{op, b, 1'b1, has, r});
  endtask

  // A received byte, sometimes preceded by a tick, an unused code or a restart.
  task automatic frame_byte(input logic [7:0] b);
    int unsigned pick;
    pick = $urandom_range(0, 199);
    if (pick < 16) send_item(OP_TICK, 8'($urandom));
    else if (pick < 18) send_item(OP_UNUSED, 8'($urandom));
    else if (pick == 18) send_item(OP_START, 8'($urandom));
    send_item(OP_BYTE, b);
  endtask

  task automatic send_frame();
    int unsigned pick;
    int          k;
    logic [15:0] frame_len;
    logic [15:0] sum;
    logic [15:0] crc;
    logic [7:0]  pid;
    logic [7:0]  pb;
    if ($urandom_range(0, 9) != 0) send_item(OP_START, 8'($urandom));
    repeat ($urandom_range(0, 2)) frame_byte(8'($urandom));
    frame_byte(($urandom_range(0, 11) == 0) ? 8'($urandom) : HDR_BYTE0);
    frame_byte(($urandom_range(0, 11) == 0) ? 8'($urandom) : HDR_BYTE1);
    repeat (4) frame_byte(8'($urandom));
    pid  = 8'($urandom);
    pick = $urandom_range(0, 39);
    if (pick == 0) frame_len = 16'($urandom_range(0, 1));
    else if (pick < 6) frame_len = CRC_BYTES;
    else if (pick == 39) frame_len = 16'($urandom_range(256, 300));
    else frame_len = 16'($urandom_range(3, 24));
    sum = {8'h00, pid} + {8'h00, frame_len[15:8]} + {8'h00, frame_len[7:0]};
    frame_byte(pid);
    frame_byte(frame_len[15:8]);
    frame_byte(frame_len[7:0]);
    if (frame_len < CRC_BYTES) return;
    for (k = 0; k < int'(frame_len - CRC_BYTES); k++) begin
      if ($urandom_range(0, 149) == 0) return;
      pb  = 8'($urandom);
      sum = sum + {8'h00, pb};
      frame_byte(pb);
    end
    crc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : sum;
    frame_byte(crc[15:8]);
    frame_byte(crc[7:0]);
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      int unsigned stall;
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{kind: out_kind, pay_index: out_payload_index, data_byte: out_data_byte,
              status: out_status, cause: out_error_cause,
              confirm: out_confirmation_code, count: out_payload_count};
      if (awaited_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: kind=%0d idx=%0d data=%h st=%0d cause=%0d conf=%h cnt=%0d",
                   got.kind, got.pay_index, got.data_byte, got.status, got.cause,
                   got.confirm, got.count);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          if (fail_count < 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected kind=%0d idx=%0d data=%h st=%0d cause=%0d conf=%h cnt=%0d",
                     want.kind, want.pay_index, want.data_byte, want.status, want.cause,
                     want.confirm, want.count);
            $display("  actual   kind=%0d idx=%0d data=%h st=%0d cause=%0d conf=%h cnt=%0d",
                     got.kind, got.pay_index, got.data_byte, got.status, got.cause,
                     got.confirm, got.count);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    result_t ok_empty;
    result_t len_err;
    in_valid     <= 1'b0;
    in_operation <= OP_START;
    in_rx_byte   <= 8'h00;
    out_ready    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_TIMEOUT;
    cfg_data     <= 16'h0000;
    rst_n        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ok_empty = '{kind: KIND_FINISH, status: 1'b0, cause: CAUSE_NONE, default: '0};
    len_err  = '{kind: KIND_FINISH, status: 1'b1, cause: CAUSE_LENGTH, default: '0};
    add_typed(OP_TICK, 8'h00, 1'b0, '0);
    add_typed(OP_UNUSED, 8'hFF, 1'b0, '0);
    add_typed(OP_START, 8'h00, 1'b0, '0);
    add_row(OP_BYTE, HDR_BYTE0);
    add_row(OP_BYTE, HDR_BYTE1);
    add_row(OP_BYTE, 8'hFF);
    add_row(OP_BYTE, 8'h00);
    add_row(OP_BYTE, 8'hFF);
    add_row(OP_BYTE, 8'h00);
    add_row(OP_BYTE, 8'h07);
    add_row(OP_BYTE, 8'h00);
    add_row(OP_BYTE, 8'h02);
    add_row(OP_BYTE, 8'h00);
    add_typed(OP_BYTE, 8'h09, 1'b1, ok_empty);
    add_row(OP_START, 8'hFF);
    add_row(OP_BYTE, HDR_BYTE0);
    add_row(OP_BYTE, HDR_BYTE1);
    repeat (4) add_row(OP_BYTE, 8'h00);
    add_row(OP_BYTE, 8'hFF);
    add_row(OP_BYTE, 8'h00);
    add_typed(OP_BYTE, 8'h01, 1'b1, len_err);
    add_row(OP_START, 8'h00);
    add_row(OP_UNUSED, 8'h00);
    add_row(OP_TICK, 8'hFF);
    add_row(OP_START, 8'h00);
    foreach (stim_rows[i])
      send_item(stim_rows[i].op, stim_rows[i].b, stim_rows[i].typed,
                stim_rows[i].has, stim_rows[i].r);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      int goal;
      calm = 1'b0;
      settle();
      write_config(PHASE_TIMEOUT[ph], PHASE_CAPACITY[ph]);
      goal = fed_items + PHASE_ITEMS;
      while (fed_items < goal) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 24) == 0) settle();
        send_frame();
      end
    end

    calm = 1'b0;
    settle();
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : sensor_packet_deframer_top_tb

/* files.f */
sv/spd_pkg.sv
sv/spd_in_stage.sv
sv/spd_parser.sv
sv/sensor_packet_deframer_top.sv
dv/sensor_packet_deframer_top_tb.sv
